FILE: rtl/interquartile_mean_filter_defines.svh
// Assertion macros shared by the interquartile mean filter RTL.
`ifndef INTERQUARTILE_MEAN_FILTER_DEFINES_SVH
`define INTERQUARTILE_MEAN_FILTER_DEFINES_SVH

// Same-cycle implication, checked on aclk outside reset
`define IQM_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("iqm assertion failed");

// Next-cycle implication, checked on aclk outside reset
`define IQM_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("iqm assertion failed");

`endif

FILE: rtl/iqm_pkg.sv
// Package: constants and item types of the interquartile mean filter.
`default_nettype none

package iqm_pkg;

    localparam int          MAX_SAMPLES_DEF = 64;
    localparam int          VALUE_W         = 16;
    localparam logic [15:0] OFFSET_RESET    = 16'd2889;   // about 11.2852 in Q8.8
    localparam logic [15:0] VALUE_MAX       = 16'hFFFF;

    // Operation codes carried in the op field
    localparam logic OP_STORE   = 1'b0;
    localparam logic OP_COMPUTE = 1'b1;

    typedef struct packed {
        logic               op;
        logic [VALUE_W-1:0] sample_value;
    } iqm_in_t;

    typedef struct packed {
        logic [VALUE_W-1:0] mean_value;
        logic               empty_res;
        logic               dropped;
    } iqm_out_t;

endpackage

`default_nettype wire

FILE: rtl/interquartile_mean_filter.sv
// Top level: interquartile mean filter with sorted sample store and serial divider.
//
//   channel   | dir | payload              | handshake
//   s_        | in  | iqm_in_t  (op, value) | s_valid / s_ready
//   m_        | out | iqm_out_t (mean,flags)| m_valid / m_ready
//   cfg_      | in  | 16-bit sample offset | cfg_wr_en, no wait
//
// A store item keeps s_ready low while the single-port walk reads and compares each stored entry
// larger than the new one and shifts it up, then puts the key (a put state when it lands at the
// bottom); a dropped item never lowers it. A compute item keeps s_ready low for a read and an add
// per middle entry and a divide step per bit, then the result state; an empty range goes straight there.
// Reset is synchronous, active low; the store itself is not cleared, only the count and control registers.
// A pending result in the output register stalls only a compute item at its end.
`default_nettype none

module interquartile_mean_filter #(
    parameter int MAX_SAMPLES = iqm_pkg::MAX_SAMPLES_DEF
) (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         s_valid,
    output logic                              s_ready,
    input  wire iqm_pkg::iqm_in_t             s_data,
    output logic                              m_valid,
    input  wire logic                         m_ready,
    output iqm_pkg::iqm_out_t                 m_data,
    input  wire logic                         cfg_wr_en,
    input  wire logic [iqm_pkg::VALUE_W-1:0]  cfg_wr_data
);

    import iqm_pkg::*;

`include "interquartile_mean_filter_defines.svh"

    localparam int AW    = $clog2(MAX_SAMPLES);
    localparam int CW    = $clog2(MAX_SAMPLES + 1);
    localparam int SUM_W = VALUE_W + AW;
    localparam int BW    = $clog2(SUM_W);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_INS_RD,
        ST_INS_CMP,
        ST_INS_PUT,
        ST_SUM_RD,
        ST_SUM_ACC,
        ST_DIV,
        ST_RES
    } state_t;

    state_t              state_reg;
    logic [VALUE_W-1:0]  offset_reg;
    logic [CW-1:0]       count_reg;
    logic                overflow_reg;
    logic [AW-1:0]       idx_reg;
    logic [AW-1:0]       end_reg;
    logic [CW-1:0]       len_reg;
    logic [VALUE_W-1:0]  key_reg;
    logic [SUM_W-1:0]    sum_reg;
    logic [CW-1:0]       rem_reg;
    logic [BW-1:0]       bit_reg;
    logic                empty_reg;
    logic                drop_reg;
    logic                m_valid_reg;
    iqm_out_t            m_data_reg;

    logic [VALUE_W-1:0]  mem [MAX_SAMPLES];
    logic [VALUE_W-1:0]  rd_data_reg;

    logic                s_fire;
    logic                out_free;
    logic [VALUE_W:0]    offs_sum;
    logic [VALUE_W-1:0]  key_next;
    logic [CW+1:0]       three_n;
    logic [CW-1:0]       lo_next;
    logic [CW-1:0]       hi_next;
    logic                mem_wr_en;
    logic [AW-1:0]       mem_rd_addr;
    logic [VALUE_W-1:0]  mem_wr_data;
    logic [CW:0]         rem_shift;
    logic                rem_ge;
    logic [CW:0]         rem_diff;
    logic                sum_last;

    assign s_ready  = (state_reg == ST_IDLE);
    assign s_fire   = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;
    assign m_valid  = m_valid_reg;
    assign m_data   = m_data_reg;

    // Add the offset and saturate at full scale
    assign offs_sum = {1'b0, s_data.sample_value} + {1'b0, offset_reg};
    assign key_next = offs_sum[VALUE_W] ? VALUE_MAX : offs_sum[VALUE_W-1:0];

    // Middle range bounds: from (n-1)/4 up to, not including, 3n/4
    assign three_n = {2'b00, count_reg} + {1'b0, count_reg, 1'b0};
    assign lo_next = (count_reg == '0) ? '0 : ((count_reg - 1'b1) >> 2);
    assign hi_next = three_n[CW+1:2];

    // Memory port control
    assign mem_rd_addr = (state_reg == ST_INS_RD) ? (idx_reg - 1'b1) : idx_reg;
    assign mem_wr_en   = (state_reg == ST_INS_PUT) || (state_reg == ST_INS_CMP);
    assign mem_wr_data = ((state_reg == ST_INS_CMP) && (rd_data_reg > key_reg))
                         ? rd_data_reg : key_reg;

    // Restoring divide step
    assign rem_shift = {rem_reg, sum_reg[SUM_W-1]};
    assign rem_ge    = rem_shift >= {1'b0, len_reg};
    assign rem_diff  = rem_shift - {1'b0, len_reg};

    assign sum_last  = ((AW+1)'(idx_reg) + 1'b1) == {1'b0, end_reg};

    // Sample store: one write, one registered read per cycle
    always_ff @(posedge aclk) begin
        if (mem_wr_en) begin
            mem[idx_reg] <= mem_wr_data;
        end
        rd_data_reg <= mem[mem_rd_addr];
    end

    // Sequencer, control and result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            offset_reg   <= OFFSET_RESET;
            count_reg    <= '0;
            overflow_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                offset_reg <= cfg_wr_data;
            end
            // Release the result once taken, unless a new one is posted this cycle
            if (m_valid_reg && m_ready && (state_reg != ST_RES)) begin
                m_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                ST_IDLE: begin
                    if (s_fire) begin
                        if (s_data.op == OP_STORE) begin
                            key_reg <= key_next;
                            idx_reg <= count_reg[AW-1:0];
                            if (count_reg == CW'(MAX_SAMPLES)) begin
                                overflow_reg <= 1'b1;
                            end else if (count_reg == '0) begin
                                state_reg <= ST_INS_PUT;
                            end else begin
                                state_reg <= ST_INS_RD;
                            end
                        end else begin
                            // Snapshot the bounds and drop flag, then empty the store by clearing the count
                            drop_reg     <= overflow_reg;
                            overflow_reg <= 1'b0;
                            count_reg    <= '0;
                            idx_reg      <= lo_next[AW-1:0];
                            end_reg      <= hi_next[AW-1:0];
                            len_reg      <= hi_next - lo_next;
                            sum_reg      <= '0;
                            rem_reg      <= '0;
                            bit_reg      <= BW'(SUM_W - 1);
                            if (hi_next > lo_next) begin
                                empty_reg <= 1'b0;
                                state_reg <= ST_SUM_RD;
                            end else begin
                                empty_reg <= 1'b1;
                                state_reg <= ST_RES;
                            end
                        end
                    end
                end
                ST_INS_RD: begin
                    state_reg <= ST_INS_CMP;
                end
                ST_INS_CMP: begin
                    // Shift a larger entry up, or drop the key into its slot
                    if (rd_data_reg > key_reg) begin
                        idx_reg   <= idx_reg - 1'b1;
                        state_reg <= (idx_reg == AW'(1)) ? ST_INS_PUT : ST_INS_RD;
                    end else begin
                        count_reg <= count_reg + 1'b1;
                        state_reg <= ST_IDLE;
                    end
                end
                ST_INS_PUT: begin
                    count_reg <= count_reg + 1'b1;
                    state_reg <= ST_IDLE;
                end
                ST_SUM_RD: begin
                    state_reg <= ST_SUM_ACC;
                end
                ST_SUM_ACC: begin
                    sum_reg   <= sum_reg + SUM_W'(rd_data_reg);
                    idx_reg   <= idx_reg + 1'b1;
                    state_reg <= sum_last ? ST_DIV : ST_SUM_RD;
                end
                ST_DIV: begin
                    rem_reg <= rem_ge ? rem_diff[CW-1:0] : rem_shift[CW-1:0];
                    sum_reg <= {sum_reg[SUM_W-2:0], rem_ge};
                    bit_reg <= bit_reg - 1'b1;
                    if (bit_reg == '0) begin
                        state_reg <= ST_RES;
                    end
                end
                ST_RES: begin
                    // Hold until the output register is free
                    if (out_free) begin
                        m_data_reg.mean_value <= sum_reg[VALUE_W-1:0];
                        m_data_reg.empty_res  <= empty_reg;
                        m_data_reg.dropped    <= drop_reg;
                        m_valid_reg           <= 1'b1;
                        state_reg             <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    `IQM_ASSERT_NOW(a_count_bound, 1'b1, count_reg <= CW'(MAX_SAMPLES))
    `IQM_ASSERT_NOW(a_div_nonzero, state_reg == ST_DIV, len_reg != '0)
    `IQM_ASSERT_NEXT(a_full_drop,
        s_fire && (s_data.op == OP_STORE) && (count_reg == CW'(MAX_SAMPLES)),
        overflow_reg && (count_reg == CW'(MAX_SAMPLES)))
    `IQM_ASSERT_NEXT(a_compute_clears, s_fire && (s_data.op == OP_COMPUTE),
        (count_reg == '0) && !overflow_reg)
    `IQM_ASSERT_NOW(a_empty_no_mean, m_valid_reg && m_data_reg.empty_res,
        m_data_reg.mean_value == '0)

endmodule

`default_nettype wire
